// ===== rtl/wkmc_pkg.sv =====
// Shared types, constants and helpers for the windowed k-mer match counter.
// No dependencies; imported by every module under rtl/.
package wkmc_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int POS_BITS    = 32;
  localparam int CHAR_W      = 8;
  localparam int OUT_W       = 32;
  localparam int BOUND_W     = 32;
  localparam int LEN_W       = 6;
  localparam int LEN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_WORDS   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CHARS_PER_WORD = CFG_DATA_W / CHAR_W;
  localparam int WIDE_W      = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;

  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0    = 3'd0,
    REG_PAT1    = 3'd1,
    REG_PAT2    = 3'd2,
    REG_PAT3    = 3'd3,
    REG_PAT_LEN = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [WIDE_W-1:0] v);
    if (v > WIDE_W'({OUT_W{1'b1}})) begin
      return {OUT_W{1'b1}};
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/windowed_kmer_match_counter_top.sv =====
// Top level of the windowed k-mer match counter.
// Depends on wkmc_pkg and wkmc_cell.
//
// Usage:
//   Input channel (in_valid/in_ready): one sequence byte per transfer with
//   first/last marks; window_start/window_end are sampled with first.
//   Output channel (out_valid/out_ready): one result per byte marked last:
//   match_count, window_slots, usable_slots.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects pattern word 0..3
//   or pattern_length (4); always ready; write only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. A row of
//   MAX_PATTERN history cells shifts on each accepted byte and all cells
//   compare against the pattern in parallel. A result passes from its last
//   byte through the cell row, tally stage and output register.
// Reset: synchronous rst clears the cells, counters, window bounds and
//   out_valid; pattern words go to zero, pattern_length to 1.
// Stall: while a result waits on out_ready, the block keeps taking bytes
//   until the next result reaches the tally stage; then in_ready drops.
module windowed_kmer_match_counter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wkmc_pkg::CHAR_W-1:0]    base,
  input  logic                           first,
  input  logic                           last,
  input  logic [wkmc_pkg::BOUND_W-1:0]   window_start,
  input  logic [wkmc_pkg::BOUND_W-1:0]   window_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wkmc_pkg::OUT_W-1:0]     match_count,
  output logic [wkmc_pkg::OUT_W-1:0]     window_slots,
  output logic [wkmc_pkg::OUT_W-1:0]     usable_slots,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wkmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wkmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wkmc_pkg::*;

  // configuration
  logic [CFG_DATA_W-1:0] pat_words [PAT_WORDS];
  logic [CHAR_W-1:0]     pat_chars [MAX_PATTERN];
  logic [LEN_W-1:0]      pattern_length;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_IDX_W-1:0]  len_m1;

  // stage 0 (cell row and counters)
  logic                  accept;
  logic                  adv;
  logic [CHAR_W-1:0]     b_fold;
  logic [CHAR_W-1:0]     hist_vec [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;
  logic [POS_BITS-1:0]   byte_index;
  logic [POS_BITS-1:0]   byte_index_next;
  logic [BOUND_W-1:0]    start_bound;
  logic [BOUND_W-1:0]    end_bound;
  logic                  v1;
  logic                  first1;
  logic                  last1;

  // stage 1 (tally)
  logic [WIDE_W-1:0]     n_w;
  logic [WIDE_W-1:0]     len_w;
  logic [WIDE_W-1:0]     sb_w;
  logic [WIDE_W-1:0]     eb_w;
  logic [WIDE_W-1:0]     start_w;
  logic [WIDE_W-1:0]     hi_w;
  logic [WIDE_W-1:0]     pos_w;
  logic                  ge_len;
  logic                  in_win;
  logic                  hit;
  logic [OUT_W-1:0]      count_base;
  logic [OUT_W-1:0]      hit_count;
  logic [OUT_W-1:0]      hit_count_next;
  logic                  v2;
  logic                  last2;
  logic [WIDE_W-1:0]     pos2;

  // stage 2 (result)
  logic [WIDE_W-1:0]     lm1_w;
  logic [WIDE_W-1:0]     vpos_w;
  logic                  emit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_words[w] <= '0;
      end
      pattern_length <= LEN_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
          pat_words[cfg_index[1:0]] <= cfg_data;
        end
        REG_PAT_LEN: begin
          pattern_length <= cfg_data[LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    assign pat_chars[j] = fold_case(
      pat_words[j / CHARS_PER_WORD][(j % CHARS_PER_WORD)*CHAR_W +: CHAR_W]);
  end

  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
    len_m1 = LEN_IDX_W'(len_eff - LEN_W'(1));
  end

  // stall only when a result is ready to leave and the output is still full
  assign emit     = v2 & last2;
  assign adv      = !(emit && out_valid && !out_ready);
  assign in_ready = adv;
  assign accept   = in_valid & in_ready;
  assign b_fold   = fold_case(base);

  // cell i holds the byte i places back; it meets pattern char len-1-i
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    cell_ctl_t            ctl;
    logic [CHAR_W-1:0]    prev;
    logic [LEN_IDX_W-1:0] pidx;
    logic                 active;
    assign ctl    = '{en: accept, clr: (i != 0) ? first : 1'b0};
    assign pidx   = len_m1 - LEN_IDX_W'(i);
    assign active = (LEN_IDX_W'(i) <= len_m1);
    if (i == 0) begin : g_head
      assign prev = b_fold;
    end else begin : g_body
      assign prev = hist_vec[i-1];
    end
    wkmc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .char_in (prev),
      .pat_char(pat_chars[pidx]),
      .active  (active),
      .char_q  (hist_vec[i]),
      .eq      (eq_vec[i])
    );
  end

  always_comb begin
    if (first) begin
      byte_index_next = POS_BITS'(1);
    end else if (byte_index != {POS_BITS{1'b1}}) begin
      byte_index_next = byte_index + POS_BITS'(1);
    end else begin
      byte_index_next = byte_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      start_bound <= '0;
      end_bound   <= '0;
      v1          <= 1'b0;
    end else begin
      if (accept) begin
        byte_index <= byte_index_next;
        if (first) begin
          start_bound <= window_start;
          end_bound   <= window_end;
        end
      end
      if (adv) begin
        v1 <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first1 <= first;
      last1  <= last;
    end
  end

  always_comb begin
    n_w     = WIDE_W'(byte_index);
    len_w   = WIDE_W'(len_eff);
    sb_w    = WIDE_W'(start_bound);
    eb_w    = WIDE_W'(end_bound);
    ge_len  = n_w >= len_w;
    start_w = n_w - len_w;
    in_win  = (start_w >= sb_w) && (start_w < eb_w);
    hit     = (&eq_vec) & ge_len;
    hi_w    = (eb_w < n_w) ? eb_w : n_w;
    pos_w   = (ge_len && hi_w > sb_w) ? (hi_w - sb_w) : '0;
    count_base = first1 ? '0 : hit_count;
    if (hit && in_win && count_base != {OUT_W{1'b1}}) begin
      hit_count_next = count_base + OUT_W'(1);
    end else begin
      hit_count_next = count_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count <= '0;
      v2        <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      if (v1) begin
        hit_count <= hit_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      last2 <= last1;
      pos2  <= pos_w;
    end
  end

  always_comb begin
    lm1_w  = WIDE_W'(len_m1);
    vpos_w = (pos2 > lm1_w) ? (pos2 - lm1_w) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      match_count  <= hit_count;
      window_slots <= sat_out(pos2);
      usable_slots <= sat_out(vpos_w);
    end
  end

endmodule

// ===== rtl/wkmc_cell.sv =====
// One history cell: holds one sequence byte, hands it to the next cell and
// compares it with the pattern character aligned to it. Depends on wkmc_pkg.
module wkmc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  wkmc_pkg::cell_ctl_t         ctl,
  input  logic [wkmc_pkg::CHAR_W-1:0] char_in,
  input  logic [wkmc_pkg::CHAR_W-1:0] pat_char,
  input  logic                        active,
  output logic [wkmc_pkg::CHAR_W-1:0] char_q,
  output logic                        eq
);
  import wkmc_pkg::*;

  assign eq = !active || (char_q == pat_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_q <= '0;
    end else if (ctl.en) begin
      char_q <= ctl.clr ? '0 : char_in;
    end
  end

endmodule

// ===== rtl/wkmc_checker.sv =====
// Port-level checks for windowed_kmer_match_counter_top, attached by bind.
// Depends on wkmc_pkg.
module wkmc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wkmc_pkg::OUT_W-1:0]  match_count,
  input logic [wkmc_pkg::OUT_W-1:0]  window_slots,
  input logic [wkmc_pkg::OUT_W-1:0]  usable_slots
);
  import wkmc_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_count)
      && $stable(window_slots) && $stable(usable_slots))
    else $error("stalled result changed");

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output transfer is possible");

  a_valid_le_possible: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> usable_slots <= window_slots)
    else $error("usable_slots above window_slots");

endmodule

bind windowed_kmer_match_counter_top wkmc_checker u_wkmc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .match_count (match_count),
  .window_slots(window_slots),
  .usable_slots(usable_slots)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for windowed_kmer_match_counter_top: random and directed
// byte streams against an in-bench k-mer tally model, with random stalls on both sides.
// Depends on wkmc_pkg and the RTL under rtl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wkmc_pkg::*;

  localparam int WATCHDOG    = 4000;
  localparam int ITEM_TARGET = 540;

  typedef struct packed {
    logic [CHAR_W-1:0]  byte_val;
    logic               is_first;
    logic               is_last;
    logic [BOUND_W-1:0] win_start;
    logic [BOUND_W-1:0] win_end;
  } seq_byte_t;

  typedef struct packed {
    logic [OUT_W-1:0] hit_total;
    logic [OUT_W-1:0] possible;
    logic [OUT_W-1:0] usable;
  } kmer_tally_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  seq_byte_t             cur_byte = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_W-1:0]      match_count;
  logic [OUT_W-1:0]      window_slots;
  logic [OUT_W-1:0]      usable_slots;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  windowed_kmer_match_counter_top u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .base               (cur_byte.byte_val),
    .first              (cur_byte.is_first),
    .last               (cur_byte.is_last),
    .window_start       (cur_byte.win_start),
    .window_end         (cur_byte.win_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .match_count        (match_count),
    .window_slots       (window_slots),
    .usable_slots       (usable_slots),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // tally model state
  logic [CFG_DATA_W-1:0] pat_word [PAT_WORDS];
  logic [LEN_W-1:0]      pat_len_raw;
  logic [CHAR_W-1:0]     seq_tail [MAX_PATTERN];
  longint unsigned       seq_len;
  longint unsigned       hits;
  longint unsigned       win_lo;
  longint unsigned       win_hi;

  seq_byte_t   pending_bytes [$];
  kmer_tally_t expected_tallies [$];

  // stimulus-side pattern
  logic [CHAR_W-1:0] gen_pat [MAX_PATTERN];
  logic [LEN_W-1:0]  gen_len_raw;

  int  queued_bytes = 0;
  int  fault_count = 0;
  int  report_count = 0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  out_hold = 0;
  bit  in_gap_mode = 1'b0;
  int  out_mode = 0;
  bit  byte_sent = 1'b0;
  string acgt = "ACGT";

  function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic int unsigned span_of(input logic [LEN_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end
    if (raw > MAX_PATTERN) begin
      return MAX_PATTERN;
    end
    return raw;
  endfunction

  function automatic logic [CHAR_W-1:0] jumble_case(input logic [CHAR_W-1:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
      return c + 8'd32;
    end
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_in_gap();
    if (!in_gap_mode || $urandom_range(0, 99) < 65) begin
      return 0;
    end
    return gap_len();
  endfunction

  task automatic reset_tally_model();
    int i;
    for (i = 0; i < PAT_WORDS; i++) begin
      pat_word[i] = '0;
    end
    pat_len_raw = 1;
    for (i = 0; i < MAX_PATTERN; i++) begin
      seq_tail[i] = '0;
    end
    seq_len = 0;
    hits    = 0;
    win_lo  = 0;
    win_hi  = 0;
  endtask

  task automatic count_kmer_byte(input seq_byte_t b);
    int              i;
    int unsigned     span;
    bit              hit;
    longint unsigned at;
    longint unsigned top;
    longint unsigned possible;
    longint unsigned usable;
    kmer_tally_t     t;
    span = span_of(pat_len_raw);
    if (b.is_first) begin
      for (i = 0; i < MAX_PATTERN; i++) begin
        seq_tail[i] = '0;
      end
      seq_len = 0;
      hits    = 0;
      win_lo  = b.win_start;
      win_hi  = b.win_end;
    end
    for (i = MAX_PATTERN - 1; i > 0; i--) begin
      seq_tail[i] = seq_tail[i-1];
    end
    seq_tail[0] = to_upper(b.byte_val);
    if (seq_len < 64'hFFFF_FFFF) begin
      seq_len++;
    end
    if (seq_len >= span) begin
      at  = seq_len - span;
      hit = 1'b1;
      for (i = 0; i < span; i++) begin
        if (seq_tail[span-1-i] != to_upper(pat_word[i/8][(i%8)*8 +: 8])) begin
          hit = 1'b0;
        end
      end
      if (hit && at >= win_lo && at < win_hi && hits < 64'hFFFF_FFFF) begin
        hits++;
      end
    end
    if (b.is_last) begin
      possible = 0;
      usable   = 0;
      if (seq_len >= span) begin
        top      = (win_hi < seq_len) ? win_hi : seq_len;
        possible = (top > win_lo) ? top - win_lo : 0;
        usable   = (possible > span - 1) ? possible - (span - 1) : 0;
      end
      t.hit_total = hits[OUT_W-1:0];
      t.possible  = (possible > 64'hFFFF_FFFF) ? '1 : possible[OUT_W-1:0];
      t.usable    = (usable > 64'hFFFF_FFFF) ? '1 : usable[OUT_W-1:0];
      expected_tallies.push_back(t);
    end
  endtask

  task automatic check_tally();
    kmer_tally_t want;
    if (expected_tallies.size() == 0) begin
      if (report_count < 10) begin
        $display("unexpected result: match_count %0d window_slots %0d usable_slots %0d",
                 match_count, window_slots, usable_slots);
      end
      report_count++;
      fault_count++;
    end else begin
      want = expected_tallies.pop_front();
      if (want.hit_total !== match_count || want.possible !== window_slots ||
          want.usable !== usable_slots) begin
        if (report_count < 10) begin
          $display("result mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                   want.hit_total, want.possible, want.usable,
                   match_count, window_slots, usable_slots);
        end
        report_count++;
        fault_count++;
      end
    end
  endtask

  // transfer monitor and model update
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_tally();
      end
      if (in_valid && in_ready) begin
        count_kmer_byte(cur_byte);
        byte_sent = 1'b1;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_sent) begin
    end else begin
      byte_sent = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        cur_byte <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_gap = next_in_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      if (out_mode == 1 && $urandom_range(0, 99) < 20) begin
        out_hold = gap_len();
      end else if (out_mode == 2 && $urandom_range(0, 99) < 50) begin
        out_hold = gap_len();
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG) begin
      @(posedge clk);
      #1;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input bit f, input bit l,
                           input logic [31:0] ws, input logic [31:0] we);
    seq_byte_t item;
    item.byte_val  = b;
    item.is_first  = f;
    item.is_last   = l;
    item.win_start = ws;
    item.win_end   = we;
    pending_bytes.push_back(item);
    queued_bytes++;
  endtask

  task automatic push_text(input string txt, input logic [31:0] ws, input logic [31:0] we);
    int i;
    for (i = 0; i < txt.len(); i++) begin
      push_byte(txt[i], i == 0, i == txt.len() - 1,
                (i == 0) ? ws : $urandom, (i == 0) ? we : $urandom);
    end
  endtask

  task automatic wait_quiet(input int settle);
    do begin
      @(posedge clk);
      #1;
    end while (pending_bytes.size() != 0 || in_valid || expected_tallies.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PAT0:    pat_word[0] = data;
      REG_PAT1:    pat_word[1] = data;
      REG_PAT2:    pat_word[2] = data;
      REG_PAT3:    pat_word[3] = data;
      REG_PAT_LEN: pat_len_raw = data[LEN_W-1:0];
      default: begin
      end
    endcase
  endtask

  function automatic logic [CFG_DATA_W-1:0] pack_word(input int w);
    logic [CFG_DATA_W-1:0] v;
    int i;
    for (i = 0; i < 8; i++) begin
      v[i*8 +: 8] = gen_pat[w*8 + i];
    end
    return v;
  endfunction

  task automatic write_pattern();
    logic [CFG_DATA_W-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = gen_len_raw;
    cfg_write(REG_PAT0, pack_word(0));
    cfg_write(REG_PAT1, pack_word(1));
    cfg_write(REG_PAT2, pack_word(2));
    cfg_write(REG_PAT3, pack_word(3));
    cfg_write(REG_PAT_LEN, len_word);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] seq_char(input bit alpha, input int unsigned span);
    int r;
    r = $urandom_range(0, 99);
    if (alpha) begin
      if (r < 95) begin
        return jumble_case(acgt[$urandom_range(0, 3)]);
      end else if (r < 98) begin
        return jumble_case("N");
      end
      return CHAR_W'($urandom_range(0, 255));
    end
    if (r < 50) begin
      return jumble_case(gen_pat[$urandom_range(0, span - 1)]);
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  task automatic push_random_seq(input int unsigned span, input bit alpha);
    logic [7:0]  s [128];
    int          n;
    int          r;
    int          i;
    int          j;
    int          p;
    int          plants;
    logic [31:0] ws;
    logic [31:0] we;
    bit          drop_last;
    r = $urandom_range(0, 99);
    if (r < 10 && span > 1) begin
      n = $urandom_range(1, span - 1);
    end else if (r < 88) begin
      n = $urandom_range(span, span + 16);
    end else begin
      n = $urandom_range(span + 17, span + 60);
    end
    for (i = 0; i < n; i++) begin
      s[i] = seq_char(alpha, span);
    end
    if (n >= span) begin
      plants = $urandom_range(0, 2);
      for (j = 0; j < plants; j++) begin
        p = $urandom_range(0, n - span);
        for (i = 0; i < span; i++) begin
          s[p+i] = jumble_case(gen_pat[i]);
        end
      end
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      ws = 0;
      we = 32'hFFFF_FFFF;
    end else if (r < 75) begin
      ws = $urandom_range(0, n + 2);
      we = $urandom_range(0, n + 4);
    end else if (r < 88) begin
      ws = $urandom;
      we = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: begin ws = 0; we = 0; end
        1: begin ws = 32'hFFFF_FFFF; we = 32'hFFFF_FFFF; end
        2: begin ws = $urandom_range(1, n); we = ws - 1; end
        default: begin ws = 32'hFFFF_FFFF; we = 0; end
      endcase
    end
    drop_last = ($urandom_range(0, 99) < 8);
    for (i = 0; i < n; i++) begin
      push_byte(s[i], i == 0, (i == n - 1) && !drop_last,
                (i == 0) ? ws : $urandom, (i == 0) ? we : $urandom);
    end
  endtask

  task automatic push_noise();
    int cnt;
    int i;
    cnt = $urandom_range(1, 6);
    for (i = 0; i < cnt; i++) begin
      push_byte(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 10,
                $urandom_range(0, 99) < 20, $urandom, $urandom);
    end
  endtask

  initial begin
    int          phase;
    int          r;
    int          nseq;
    int          k;
    int          j;
    int unsigned span;
    bit          alpha;
    reset_tally_model();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset pattern: one zero character; bytes ahead of any first, then a one-byte sequence
    push_byte(8'h00, 1'b0, 1'b0, $urandom, $urandom);
    push_byte(8'hFF, 1'b0, 1'b0, $urandom, $urandom);
    push_byte(8'h00, 1'b0, 1'b1, $urandom, $urandom);
    push_byte(8'h00, 1'b1, 1'b1, 32'h0, 32'hFFFF_FFFF);
    // sequence carries on past last
    push_byte(8'h00, 1'b0, 1'b0, $urandom, $urandom);
    push_byte(8'h7F, 1'b0, 1'b1, $urandom, $urandom);
    wait_quiet(8);

    for (j = 0; j < MAX_PATTERN; j++) begin
      gen_pat[j] = CHAR_W'($urandom_range(0, 255));
    end
    gen_pat[0] = "a";
    gen_pat[1] = "c";
    gen_pat[2] = "g";
    gen_pat[3] = "T";
    gen_len_raw = 4;
    write_pattern();
    push_text("aCGtACGT", 32'h0, 32'hFFFF_FFFF);
    push_text("ACG", 32'h0, 32'hFFFF_FFFF);
    push_text("ACGTA", 32'hFFFF_FFFF, 32'h0);
    wait_quiet(8);

    // zero length acts as one; characters next to the lower-case range stay as they are
    gen_pat[0] = "{";
    gen_len_raw = 0;
    write_pattern();
    push_text("`{Z{", 32'd1, 32'd3);

    phase = 0;
    while (queued_bytes < ITEM_TARGET) begin
      wait_quiet(8);
      if (phase == 0) begin
        gen_len_raw = LEN_W'(MAX_PATTERN);
      end else if (phase == 1) begin
        gen_len_raw = 63;
      end else if (phase == 2) begin
        gen_len_raw = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          gen_len_raw = LEN_W'($urandom_range(1, 8));
        end else if (r < 85) begin
          gen_len_raw = LEN_W'($urandom_range(9, MAX_PATTERN));
        end else begin
          case ($urandom_range(0, 3))
            0: gen_len_raw = 1;
            1: gen_len_raw = LEN_W'(MAX_PATTERN);
            2: gen_len_raw = 0;
            default: gen_len_raw = LEN_W'($urandom_range(MAX_PATTERN + 1, 63));
          endcase
        end
      end
      span  = span_of(gen_len_raw);
      alpha = ($urandom_range(0, 99) < 80);
      for (j = 0; j < MAX_PATTERN; j++) begin
        if (j < span && alpha) begin
          gen_pat[j] = jumble_case(acgt[$urandom_range(0, 3)]);
        end else begin
          gen_pat[j] = CHAR_W'($urandom_range(0, 255));
        end
      end
      write_pattern();
      in_gap_mode = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      out_mode = (r < 25) ? 0 : (r < 75) ? 1 : 2;
      nseq = $urandom_range(3, 7);
      for (k = 0; k < nseq && queued_bytes < ITEM_TARGET; k++) begin
        if ($urandom_range(0, 99) < 85) begin
          push_random_seq(span, alpha);
        end else begin
          push_noise();
        end
        // sender holds off until every pending result is back
        if ((phase == 0 && k == 1) || $urandom_range(0, 99) < 8) begin
          wait_quiet(0);
        end
      end
      phase++;
    end

    wait_quiet(20);
    fault_count += expected_tallies.size();
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
